/* rtl/bce_pkg.sv */
package bce_pkg;

  localparam int OUT_W         = 11;
  localparam int CFG_AW        = 4;
  localparam int SIZE_W        = 14;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [7:0] THRESHOLD_RESET = 8'd220;
  localparam int         FRAME_W_RESET   = 640;
  localparam int         FRAME_H_RESET   = 480;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_FRAME_W   = 2'd1;
  localparam logic [1:0] REG_FRAME_H   = 2'd2;

  // one queued pixel word: up to two results, interior one first
  typedef struct packed {
    logic [OUT_W-1:0] col;
    logic [OUT_W-1:0] row;
    logic             has_int;
    logic             int_white;
    logic             has_bord;
    logic             bord_white;
  } item_t;

endpackage

/* rtl/bce_front.sv */
module bce_front import bce_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_red_level,
  input  logic [7:0]    in_green_level,
  input  logic [7:0]    in_blue_level,
  input  logic [7:0]    threshold,
  input  logic [CW-1:0] last_col,
  input  logic [RW-1:0] last_row,
  input  logic          q_full,
  output logic          push,
  output item_t         push_item
);

  logic [1:0]       line_mem [MAX_WIDTH];

  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_b_r;
  logic             s1_int_r;
  logic             s1_bord_r;
  logic [CW-1:0]    s1_addr_r;
  logic [OUT_W-1:0] s1_col_r;
  logic [OUT_W-1:0] s1_row_r;
  logic [1:0]       rd_r;
  logic             fwd_r;
  logic [1:0]       fwd_data_r;
  logic [8:0]       window_r, window_nxt;

  logic       accept;
  logic       s1_adv;
  logic       has_any;
  logic       pix_white;
  logic       row_end;
  logic       frame_end;
  logic       is_int;
  logic       is_bord;
  logic [1:0] line_word;
  logic       int_white;

  always_comb begin
    pix_white = (in_red_level >= threshold) && (in_green_level >= threshold) &&
                (in_blue_level >= threshold);
    row_end   = col_r >= last_col;
    frame_end = row_r >= last_row;
    is_int    = (col_r >= CW'(2)) && (row_r >= RW'(2)) &&
                (col_r <= last_col) && (row_r <= last_row);
    is_bord   = (col_r == '0) || (row_r == '0) || row_end || frame_end;

    // bit 0 row two up, bit 1 row just above; bypass a write at the same column
    line_word  = fwd_r ? fwd_data_r : rd_r;
    window_nxt = {s1_b_r, line_word[1], line_word[0], window_r[8:3]};
    int_white  = window_nxt[4] && (window_nxt != 9'h1FF);

    has_any  = s1_int_r || s1_bord_r;
    s1_adv   = s1_valid_r && (!has_any || !q_full);
    in_stall = s1_valid_r && !s1_adv;
    accept   = in_valid && !in_stall;

    push                 = s1_adv && has_any;
    push_item.col        = s1_col_r;
    push_item.row        = s1_row_r;
    push_item.has_int    = s1_int_r;
    push_item.int_white  = int_white;
    push_item.has_bord   = s1_bord_r;
    push_item.bord_white = s1_b_r;

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end

    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      window_r   <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (s1_adv) begin
        window_r <= window_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_addr_r] <= {s1_b_r, line_word[1]};
    end
    if (accept) begin
      rd_r       <= line_mem[col_r];
      fwd_r      <= s1_adv && (s1_addr_r == col_r);
      fwd_data_r <= {s1_b_r, line_word[1]};
      s1_b_r     <= pix_white;
      s1_int_r   <= is_int;
      s1_bord_r  <= is_bord;
      s1_addr_r  <= col_r;
      s1_col_r   <= OUT_W'(col_r);
      s1_row_r   <= OUT_W'(row_r);
    end
  end

endmodule

/* rtl/bce_fifo.sv */
module bce_fifo import bce_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;
  logic          do_push, do_pop;

  always_comb begin
    empty   = count_r == '0;
    full    = count_r == NW'(DEPTH);
    do_push = push && !full;
    do_pop  = pop && !empty;
    head    = slots[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + NW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/bce_back.sv */
module bce_back import bce_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  item_t            head,
  input  logic             q_empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_pixel_column,
  output logic [OUT_W-1:0] out_pixel_row,
  output logic             out_is_white,
  output logic             out_last_of_run
);

  logic             out_valid_r, out_valid_nxt;
  logic             phase_r, phase_nxt;
  logic [OUT_W-1:0] col_r, col_nxt;
  logic [OUT_W-1:0] row_r, row_nxt;
  logic             white_r, white_nxt;
  logic             last_r, last_nxt;
  logic             load;

  always_comb begin
    load          = !out_valid_r || !out_stall;
    pop           = 1'b0;
    phase_nxt     = phase_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    white_nxt     = white_r;
    last_nxt      = last_r;
    out_valid_nxt = load ? !q_empty : out_valid_r;
    if (load && !q_empty) begin
      if (head.has_int && !phase_r) begin
        // interior result sits one column left, one row up
        col_nxt   = head.col - OUT_W'(1);
        row_nxt   = head.row - OUT_W'(1);
        white_nxt = head.int_white;
        last_nxt  = !head.has_bord;
        if (head.has_bord) begin
          phase_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        col_nxt   = head.col;
        row_nxt   = head.row;
        white_nxt = head.bord_white;
        last_nxt  = 1'b1;
        phase_nxt = 1'b0;
        pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    white_r <= white_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_column = col_r;
  assign out_pixel_row    = row_r;
  assign out_is_white     = white_r;
  assign out_last_of_run  = last_r;

endmodule

/* rtl/binary_contour_extract_top.sv */
// Binary contour extraction over a raster pixel stream.
// Input channel: one RGB pixel per word (in_red_level, in_green_level,
// in_blue_level), raster order, frame size from frame_width/frame_height.
// A pixel is white when all three channels reach white_threshold.
// Output channel: one word per result pixel with its column and row;
// border pixels come out for the pixel just taken, interior pixels once
// their lower-right neighbor arrives, so one input can give zero, one or
// two words. out_last_of_run marks the final word of an input.
// Throughput: one pixel per cycle while in_stall stays low; a pixel with
// two results holds the output register for both words in turn. A result
// word passes the classifier register, the queue and the output register.
// Two 1-bit line stores live in one MAX_WIDTH x 2 bit memory, read when a
// pixel is taken and written when that pixel moves on to the queue
// (held back while the queue is full); a 4-word queue decouples the
// classifier from the output stage. When the receiver stalls the queue
// fills and in_stall rises. Reset clears the position counters, window
// and queue and loads the default registers; the line stores need no
// clearing. Registers (APB, byte address 4*i): white_threshold,
// frame_width, frame_height; write only while the stream is idle.
module binary_contour_extract_top import bce_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_red_level,
  input  logic [7:0]        in_green_level,
  input  logic [7:0]        in_blue_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  out_pixel_column,
  output logic [OUT_W-1:0]  out_pixel_row,
  output logic              out_is_white,
  output logic              out_last_of_run,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int RstLastCol = ((FRAME_W_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_W_RESET) - 1;
  localparam int RstLastRow = ((FRAME_H_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_H_RESET) - 1;

  logic [7:0]        threshold_r;
  logic [11:0]       frame_w_r;
  logic [11:0]       frame_h_r;
  logic [CW-1:0]     last_col_r;
  logic [RW-1:0]     last_row_r;
  logic              wr_en;
  logic [1:0]        reg_idx;
  logic [SIZE_W-1:0] size_ext;
  logic [CW-1:0]     last_col_wr;
  logic [RW-1:0]     last_row_wr;

  logic  q_full, q_empty, push, pop;
  item_t push_item, head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // sizes saturate to 1..MAX, kept as last index
  always_comb begin
    size_ext = {{(SIZE_W-12){1'b0}}, pwdata[11:0]};
    if (size_ext == '0) begin
      last_col_wr = '0;
      last_row_wr = '0;
    end else begin
      last_col_wr = (size_ext > SIZE_W'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) :
                    CW'(size_ext - SIZE_W'(1));
      last_row_wr = (size_ext > SIZE_W'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1) :
                    RW'(size_ext - SIZE_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      frame_w_r   <= 12'(FRAME_W_RESET);
      frame_h_r   <= 12'(FRAME_H_RESET);
      last_col_r  <= CW'(RstLastCol);
      last_row_r  <= RW'(RstLastRow);
    end else if (wr_en) begin
      case (reg_idx)
        REG_THRESHOLD: threshold_r <= pwdata[7:0];
        REG_FRAME_W: begin
          frame_w_r  <= pwdata[11:0];
          last_col_r <= last_col_wr;
        end
        REG_FRAME_H: begin
          frame_h_r  <= pwdata[11:0];
          last_row_r <= last_row_wr;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = {24'd0, threshold_r};
      REG_FRAME_W:   prdata = {20'd0, frame_w_r};
      REG_FRAME_H:   prdata = {20'd0, frame_h_r};
      default:       prdata = '0;
    endcase
  end

  bce_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red_level  (in_red_level),
    .in_green_level(in_green_level),
    .in_blue_level (in_blue_level),
    .threshold     (threshold_r),
    .last_col      (last_col_r),
    .last_row      (last_row_r),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  bce_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  bce_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_column(out_pixel_column),
    .out_pixel_row   (out_pixel_row),
    .out_is_white    (out_is_white),
    .out_last_of_run (out_last_of_run)
  );

endmodule

/* rtl/bce_checker.sv */
module bce_checker import bce_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [7:0]        in_red_level,
  input logic [7:0]        in_green_level,
  input logic [7:0]        in_blue_level,
  input logic              out_valid,
  input logic              out_stall,
  input logic [OUT_W-1:0]  out_pixel_column,
  input logic [OUT_W-1:0]  out_pixel_row,
  input logic              out_is_white,
  input logic              out_last_of_run,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [CFG_AW-1:0] paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata,
  input logic              pready
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_column) &&
    $stable(out_pixel_row) && $stable(out_is_white) && $stable(out_last_of_run))
    else $error("stalled output word changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // interior word of a pair is followed at once by its border word
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("second word of a pixel did not follow");

  a_pair_coords: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=>
    (out_pixel_column == $past(out_pixel_column) + 11'd1) &&
    (out_pixel_row == $past(out_pixel_row) + 11'd1))
    else $error("border word not at lower right of interior word");

endmodule

bind binary_contour_extract_top bce_checker u_bce_checker (.*);

/* tb/bce_contour_checker.sv */
module bce_contour_checker import bce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_red_level,
  input  logic [7:0]        in_green_level,
  input  logic [7:0]        in_blue_level,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [OUT_W-1:0]  out_pixel_column,
  input  logic [OUT_W-1:0]  out_pixel_row,
  input  logic              out_is_white,
  input  logic              out_last_of_run,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                mismatch_count,
  output int                words_outstanding
);

  typedef struct packed {
    logic [OUT_W-1:0] col;
    logic [OUT_W-1:0] row;
    logic             white;
    logic             last;
  } contour_px_t;

  contour_px_t pending_pixels[$];

  logic [7:0]  thresh;
  logic [11:0] frame_w;
  logic [11:0] frame_h;

  int unsigned               col_pos;
  int unsigned               row_pos;
  bit [MAX_WIDTH_DEF-1:0]    upper_line;
  bit [MAX_WIDTH_DEF-1:0]    middle_line;
  logic [8:0]                window;

  initial begin
    mismatch_count = 0;
    words_outstanding = 0;
  end

  function automatic int unsigned clamp_size(logic [11:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < 100)
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic classify_pixel(input logic [7:0] red, input logic [7:0] green,
                                input logic [7:0] blue);
    int unsigned w, h, c, r;
    logic px, up, mid, has_int, has_bord;
    contour_px_t word;
    w = clamp_size(frame_w, MAX_WIDTH_DEF);
    h = clamp_size(frame_h, MAX_HEIGHT_DEF);
    c = col_pos;
    r = row_pos;
    px = (red >= thresh) && (green >= thresh) && (blue >= thresh);
    up = 1'b0;
    mid = 1'b0;
    if (c < MAX_WIDTH_DEF) begin
      up = upper_line[c];
      mid = middle_line[c];
      upper_line[c] = mid;
      middle_line[c] = px;
    end
    // newest column enters at the top: {current, middle, upper}
    window = {px, mid, up, window[8:3]};
    has_int = (c >= 2) && (r >= 2) && (c <= w - 1) && (r <= h - 1);
    has_bord = (c == 0) || (r == 0) || (c >= w - 1) || (r >= h - 1);
    if (has_int) begin
      word.col = OUT_W'(c - 1);
      word.row = OUT_W'(r - 1);
      // interior white survives only next to a black neighbor
      word.white = window[4] && (window != 9'h1FF);
      word.last = !has_bord;
      pending_pixels.push_back(word);
    end
    if (has_bord) begin
      word.col = OUT_W'(c);
      word.row = OUT_W'(r);
      word.white = px;
      word.last = 1'b1;
      pending_pixels.push_back(word);
    end
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_word();
    contour_px_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch("word with nothing expected, column", out_pixel_column, 0);
    end else begin
      want = pending_pixels.pop_front();
      if (out_pixel_column !== want.col)
        report_mismatch("pixel_column", out_pixel_column, want.col);
      if (out_pixel_row !== want.row)
        report_mismatch("pixel_row", out_pixel_row, want.row);
      if (out_is_white !== want.white)
        report_mismatch("is_white", out_is_white, want.white);
      if (out_last_of_run !== want.last)
        report_mismatch("last_of_run", out_last_of_run, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thresh = THRESHOLD_RESET;
      frame_w = 12'(FRAME_W_RESET);
      frame_h = 12'(FRAME_H_RESET);
      col_pos = 0;
      row_pos = 0;
      upper_line = '0;
      middle_line = '0;
      window = '0;
      pending_pixels.delete();
    end else begin
      if (in_valid && !in_stall)
        classify_pixel(in_red_level, in_green_level, in_blue_level);
      if (out_valid && !out_stall)
        check_word();
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_THRESHOLD: thresh = pwdata[7:0];
          REG_FRAME_W:   frame_w = pwdata[11:0];
          REG_FRAME_H:   frame_h = pwdata[11:0];
          default: ;
        endcase
      end
    end
    words_outstanding = pending_pixels.size();
  end

endmodule

/* tb/binary_contour_extract_top_test.sv */
module binary_contour_extract_top_test;
  import bce_pkg::*;

  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_red_level;
  logic [7:0]        in_green_level;
  logic [7:0]        in_blue_level;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OUT_W-1:0]  out_pixel_column;
  logic [OUT_W-1:0]  out_pixel_row;
  logic              out_is_white;
  logic              out_last_of_run;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int mismatch_count;
  int words_outstanding;

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  bit hold_ack = 1'b0;
  int hold_left = 0;

  int cur_thr;
  int cur_w;
  int cur_h;

  always #5 clk = ~clk;

  binary_contour_extract_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red_level     (in_red_level),
    .in_green_level   (in_green_level),
    .in_blue_level    (in_blue_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_column (out_pixel_column),
    .out_pixel_row    (out_pixel_row),
    .out_is_white     (out_is_white),
    .out_last_of_run  (out_last_of_run),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  bce_contour_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_red_level      (in_red_level),
    .in_green_level    (in_green_level),
    .in_blue_level     (in_blue_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_column  (out_pixel_column),
    .out_pixel_row     (out_pixel_row),
    .out_is_white      (out_is_white),
    .out_last_of_run   (out_last_of_run),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .mismatch_count    (mismatch_count),
    .words_outstanding (words_outstanding)
  );

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_ack) begin
      hold_ack <= hold_go;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pwrite && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_gap_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // wait for the pipe to drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (words_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_config(input int thr, input int fw, input int fh);
    cfg_write(REG_THRESHOLD, 32'(thr));
    cfg_write(REG_FRAME_W, 32'(fw));
    cfg_write(REG_FRAME_H, 32'(fh));
    cur_thr = thr;
    cur_w = (fw == 0) ? 1 : (fw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : fw;
    cur_h = (fh == 0) ? 1 : (fh > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : fh;
  endtask

  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red_level <= red;
    in_green_level <= green;
    in_blue_level <= blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_pixel(input int white_pct);
    logic [7:0] lv[3];
    int k;
    if ($urandom_range(9) == 0) begin
      foreach (lv[i]) lv[i] = 8'($urandom_range(255));
    end else if (cur_thr == 0 || $urandom_range(99) < white_pct) begin
      foreach (lv[i]) lv[i] = 8'($urandom_range(255, cur_thr));
    end else begin
      k = $urandom_range(2);
      foreach (lv[i]) lv[i] = 8'($urandom_range(255));
      lv[k] = 8'($urandom_range(cur_thr - 1, 0));
    end
    send_pixel(lv[0], lv[1], lv[2]);
  endtask

  // whole frames only, so every register change lands on a frame boundary
  task automatic random_frames(input int n_items);
    int sent, thr, fw, fh, wp;
    sent = 0;
    while (sent < n_items) begin
      if (sent == 0 || $urandom_range(1) == 1) begin
        settle();
        case ($urandom_range(9))
          0:       thr = 0;
          1:       thr = 255;
          default: thr = $urandom_range(250, 60);
        endcase
        fw = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(12, 3);
        fh = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(8, 3);
        load_config(thr, fw, fh);
      end
      case ($urandom_range(3))
        0:       wp = 15;
        1:       wp = 70;
        2:       wp = 92;
        default: wp = 100;
      endcase
      for (int i = 0; i < cur_w * cur_h; i++) send_random_pixel(wp);
      sent += cur_w * cur_h;
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_red_level = '0;
    in_green_level = '0;
    in_blue_level = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_idle(33, 67);

    // 5x4 frame: two fully surrounded interior whites get hollowed out,
    // the others sit next to a black pixel; whites at exactly the threshold
    load_config(220, 5, 4);
    for (int i = 0; i < 20; i++) begin
      if (i == 4)
        send_pixel(8'd255, 8'd219, 8'd255);
      else if (i == 13)
        send_pixel(8'd0, 8'd0, 8'd0);
      else if (i == 19)
        send_pixel(8'd219, 8'd255, 8'd255);
      else if (i % 2 == 1)
        send_pixel(8'd255, 8'd255, 8'd255);
      else
        send_pixel(8'd220, 8'd220, 8'd220);
    end
    // zero width saturates to one column
    settle();
    load_config(0, 0, 2);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd17, 8'd128, 8'd3);
    // zero height saturates to one row
    settle();
    load_config(255, 2, 0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd255);

    // receiver holds off while part of a frame streams in, then the size
    // shrinks in mid-frame: the next pixel ends both its row and the frame
    settle();
    set_idle(0, 0);
    load_config(150, 8, 6);
    hold_go <= ~hold_go;
    for (int i = 0; i < 20; i++) send_random_pixel(70);
    settle();
    load_config(150, 3, 3);
    send_random_pixel(70);

    set_idle(33, 67);
    random_frames(220);
    settle();
    set_idle(67, 33);
    random_frames(220);
    settle();
    set_idle(0, 0);
    random_frames(220);

    // register maxima: a stretch of an oversized single-column frame,
    // then part of an oversized single-row frame over columns already seen
    settle();
    load_config(200, 1, 4095);
    for (int i = 0; i < 24; i++) send_random_pixel(50);
    settle();
    load_config(200, 4095, 1);
    for (int i = 0; i < 8; i++) send_random_pixel(50);

    settle();
    if (mismatch_count == 0 && words_outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
